### hw/rtl/rmd160_pkg.sv
// Package: shared types, constants and round tables for the RIPEMD-160 engine.
package rmd160_pkg;

    localparam int COUNT_WIDTH = 61;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_AW     = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // command from the front part to the compression back part
    typedef struct packed {
        logic        finish;   // emit digest and reinit after this block
        logic [511:0] blk;     // 64 bytes, byte 0 in bits 7:0
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_be_state;

    typedef enum logic [1:0] {
        FE_ACCEPT,
        FE_PAD_EXTRA
    } t_fe_state;

    localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                           32'h10325476, 32'hC3D2E1F0};

    localparam logic [3:0] SEL_L [80] = '{
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
        7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
        3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
        1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
        4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
    localparam logic [3:0] SEL_R [80] = '{
        5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
        6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
        15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
        8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
        12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
    localparam logic [3:0] ROT_L [80] = '{
        11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
        7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
        11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
        11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
        9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
    localparam logic [3:0] ROT_R [80] = '{
        8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
        9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
        9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
        15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
        8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
    localparam logic [31:0] ADD_L [5] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1,
                                          32'h8F1BBCDC, 32'hA953FD4E};
    localparam logic [31:0] ADD_R [5] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
                                          32'h7A6D76E9, 32'h00000000};

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] boolfn(input logic [2:0] k, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
        logic [31:0] r;
        case (k)
            3'd0:    r = x ^ y ^ z;
            3'd1:    r = (x & y) | (~x & z);
            3'd2:    r = (x | ~y) ^ z;
            3'd3:    r = (x & z) | (y & ~z);
            default: r = x ^ (y | ~z);
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/rmd160_front.sv
// Front part: gathers bytes into blocks, pads, and queues block commands.
module rmd160_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmd160_pkg::t_in_item  i_item,
    input  logic                  i_push,
    output logic                  o_full,
    output rmd160_pkg::t_cmd      o_cmd,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_full
);
    logic [511:0]                         r_buf, n_buf;
    logic [5:0]                           r_fill, n_fill;
    logic [rmd160_pkg::COUNT_WIDTH-1:0]   r_total, n_total;
    rmd160_pkg::t_fe_state                r_state, n_state;
    logic [63:0]                          bits;
    logic [511:0]                         padded;
    logic [6:0]                           fill_b;
    logic                                 wrap;

    assign bits = 64'(r_total) << 3;

    // full while the queue cannot take a command or an extra pad block is pending
    assign o_full = i_cmd_full || (r_state == rmd160_pkg::FE_PAD_EXTRA);

    always_comb begin
        n_buf   = r_buf;
        n_fill  = r_fill;
        n_total = r_total;
        n_state = r_state;
        o_cmd_valid = 1'b0;
        o_cmd   = '{finish: 1'b0, blk: r_buf};
        padded  = '0;
        fill_b  = '0;
        wrap    = 1'b0;
        if (r_state == rmd160_pkg::FE_PAD_EXTRA) begin
            if (!i_cmd_full) begin
                // r_buf holds the 0x80 marker when the message ended on a block edge
                o_cmd_valid = 1'b1;
                o_cmd.finish = 1'b1;
                o_cmd.blk = {bits, r_buf[447:0]};
                n_state = rmd160_pkg::FE_ACCEPT;
                n_total = '0;
            end
        end else if (i_push && !i_cmd_full) begin
            n_buf  = r_buf;
            fill_b = {1'b0, r_fill};
            if (i_item.has_byte) begin
                n_buf[r_fill*8 +: 8] = i_item.data_byte;
                fill_b  = fill_b + 7'd1;
                n_total = r_total + 1'b1;
                wrap    = fill_b[6];
            end
            if (wrap && !i_item.end_of_message) begin
                o_cmd_valid = 1'b1;
                o_cmd.blk = n_buf;
                n_fill = '0;
            end else if (wrap) begin
                // full block, then a pad-only block carries the length
                o_cmd_valid = 1'b1;
                o_cmd.blk = n_buf;
                n_fill = '0;
                n_buf = {448'b0, 56'b0, 8'h80};
                o_cmd.finish = 1'b0;
                n_state = rmd160_pkg::FE_PAD_EXTRA;
                n_buf = '0;
                n_buf[7:0] = 8'h80;
            end else if (i_item.end_of_message) begin
                for (int i = 0; i < 64; i++) begin
                    if (i < fill_b) padded[i*8 +: 8] = n_buf[i*8 +: 8];
                    else if (i == fill_b) padded[i*8 +: 8] = 8'h80;
                end
                n_fill = '0;
                o_cmd_valid = 1'b1;
                if (fill_b > 7'd55) begin
                    o_cmd.blk = padded;
                    n_state = rmd160_pkg::FE_PAD_EXTRA;
                    n_buf = '0;
                end else begin
                    padded[511:448] = (64'(n_total) << 3);
                    o_cmd.blk = padded;
                    o_cmd.finish = 1'b1;
                    n_total = '0;
                end
            end else begin
                n_fill = fill_b[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_total <= '0;
            r_state <= rmd160_pkg::FE_ACCEPT;
        end else begin
            r_fill  <= n_fill;
            r_total <= n_total;
            r_state <= n_state;
        end
    end
endmodule

### hw/rtl/rmd160_cmdq.sv
// Command queue between the front and back parts.
module rmd160_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rmd160_pkg::t_cmd  i_cmd,
    input  logic              i_wr,
    output logic              o_full,
    output rmd160_pkg::t_cmd  o_cmd,
    output logic              o_empty,
    input  logic              i_rd
);
    rmd160_pkg::t_cmd r_mem [rmd160_pkg::CMDQ_DEPTH];
    logic [rmd160_pkg::CMDQ_AW-1:0] r_wp, r_rp;
    logic [rmd160_pkg::CMDQ_AW:0]   r_cnt;

    assign o_full  = r_cnt == (rmd160_pkg::CMDQ_AW+1)'(rmd160_pkg::CMDQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_wr && !o_full) r_wp <= r_wp + 1'b1;
            if (i_rd && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (rmd160_pkg::CMDQ_AW+1)'(i_wr && !o_full)
                           - (rmd160_pkg::CMDQ_AW+1)'(i_rd && !o_empty);
        end
    end
endmodule

### hw/rtl/rmd160_back.sv
// Back part: 80-step compression with both lines in parallel, then digest output after a finishing block.
module rmd160_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmd160_pkg::t_cmd      i_cmd,
    input  logic                  i_cmd_empty,
    output logic                  o_cmd_rd,
    output rmd160_pkg::t_out_item o_item,
    output logic                  o_empty,
    input  logic                  i_pop
);
    rmd160_pkg::t_be_state r_state, n_state;
    logic [31:0]  r_h [5];
    logic [31:0]  r_l [5];
    logic [31:0]  r_r [5];
    logic [511:0] r_blk;
    logic         r_fin;
    logic [6:0]   r_step;
    logic [2:0]   r_widx;
    logic [2:0]   g;
    logic [31:0]  wl, wr, tl, tr;

    assign g  = 3'(r_step >> 4);
    assign wl = r_blk[rmd160_pkg::SEL_L[r_step]*32 +: 32];
    assign wr = r_blk[rmd160_pkg::SEL_R[r_step]*32 +: 32];
    assign tl = rmd160_pkg::rotl(r_l[0] + rmd160_pkg::boolfn(g, r_l[1], r_l[2], r_l[3])
                + wl + rmd160_pkg::ADD_L[g], rmd160_pkg::ROT_L[r_step]) + r_l[4];
    assign tr = rmd160_pkg::rotl(r_r[0] + rmd160_pkg::boolfn(3'd4 - g, r_r[1], r_r[2], r_r[3])
                + wr + rmd160_pkg::ADD_R[g], rmd160_pkg::ROT_R[r_step]) + r_r[4];

    always_comb begin
        n_state = r_state;
        case (r_state)
            rmd160_pkg::ST_IDLE:  if (!i_cmd_empty) n_state = rmd160_pkg::ST_ROUND;
            rmd160_pkg::ST_ROUND: if (r_step == 7'd79) n_state = rmd160_pkg::ST_FINAL;
            rmd160_pkg::ST_FINAL: n_state = r_fin ? rmd160_pkg::ST_EMIT : rmd160_pkg::ST_IDLE;
            rmd160_pkg::ST_EMIT:  if (i_pop && r_widx == 3'd4) n_state = rmd160_pkg::ST_IDLE;
            default:              n_state = rmd160_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_rd = (r_state == rmd160_pkg::ST_IDLE) && !i_cmd_empty;
        o_empty  = r_state != rmd160_pkg::ST_EMIT;
        o_item.digest_word = r_h[r_widx];
        o_item.word_index  = r_widx;
        o_item.last_word   = r_widx == 3'd4;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rmd160_pkg::ST_IDLE: begin
                r_blk <= i_cmd.blk;
                r_fin <= i_cmd.finish;
                for (int i = 0; i < 5; i++) begin
                    r_l[i] <= r_h[i];
                    r_r[i] <= r_h[i];
                end
            end
            rmd160_pkg::ST_ROUND: begin
                r_l <= '{r_l[4], tl, r_l[1], rmd160_pkg::rotl(r_l[2], 4'd10), r_l[3]};
                r_r <= '{r_r[4], tr, r_r[1], rmd160_pkg::rotl(r_r[2], 4'd10), r_r[3]};
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state <= rmd160_pkg::ST_IDLE;
            r_step  <= '0;
            r_widx  <= '0;
            r_h     <= rmd160_pkg::H_INIT;
        end else begin
            r_state <= n_state;
            if (r_state == rmd160_pkg::ST_ROUND)
                r_step <= (r_step == 7'd79) ? 7'd0 : r_step + 7'd1;
            if (r_state == rmd160_pkg::ST_FINAL) begin
                r_h[0] <= r_h[1] + r_l[2] + r_r[3];
                r_h[1] <= r_h[2] + r_l[3] + r_r[4];
                r_h[2] <= r_h[3] + r_l[4] + r_r[0];
                r_h[3] <= r_h[4] + r_l[0] + r_r[1];
                r_h[4] <= r_h[0] + r_l[1] + r_r[2];
            end
            if (r_state == rmd160_pkg::ST_EMIT && i_pop) begin
                r_widx <= (r_widx == 3'd4) ? 3'd0 : r_widx + 3'd1;
                if (r_widx == 3'd4) r_h <= rmd160_pkg::H_INIT;
            end
        end
    end
endmodule

### hw/rtl/ripemd160_hash_engine.sv
// Top level: RIPEMD-160 byte-stream hash engine.
// Usage:
//  Input queue side: drive i_item and raise push; a transfer happens on a
//  clock edge with push high and full low. Each item may carry one byte
//  (has_byte) and may close the message (end_of_message).
//  Result queue side: while empty is low, o_item holds the next digest
//  word; pop high transfers it. Five words h0..h4 follow each message end.
//  Flow: bytes are taken one per cycle, while full is low, into a 64-byte block.
//  Each block passes through the compression unit as a load step, one
//  step of both lines per cycle through all round steps, then the chaining
//  update; the front stalls (full) when the 4-entry block queue is full and
//  while an extra pad block is pending. A message end costs one or two blocks
//  plus output.
//  Receiver stall: the digest words wait in the output stage; compression
//  of queued blocks resumes after the fifth word is taken.
//  Reset (i_rst_n low, synchronous) empties the queues and restores the
//  initial chaining values.
module ripemd160_hash_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmd160_pkg::t_in_item  i_item,
    input  logic                  push,
    output logic                  full,
    output rmd160_pkg::t_out_item o_item,
    output logic                  empty,
    input  logic                  pop
);
    rmd160_pkg::t_cmd fe_cmd, q_cmd;
    logic fe_valid, q_full, q_empty, q_rd;

    rmd160_front u_front (
        .i_clk, .i_rst_n, .i_item, .i_push(push), .o_full(full),
        .o_cmd(fe_cmd), .o_cmd_valid(fe_valid), .i_cmd_full(q_full)
    );

    rmd160_cmdq u_cmdq (
        .i_clk, .i_rst_n, .i_cmd(fe_cmd), .i_wr(fe_valid), .o_full(q_full),
        .o_cmd(q_cmd), .o_empty(q_empty), .i_rd(q_rd)
    );

    rmd160_back u_back (
        .i_clk, .i_rst_n, .i_cmd(q_cmd), .i_cmd_empty(q_empty), .o_cmd_rd(q_rd),
        .o_item, .o_empty(empty), .i_pop(pop)
    );

    // never accept while the queue is full
    a_no_push_when_qfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> full) else $error("accept with full block queue");
    // the last word is always index 4
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.last_word) |-> (o_item.word_index == 3'd4))
        else $error("last word index");
    // word index advances by one after each non-final transfer
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_item.last_word) |=>
        (o_item.word_index == $past(o_item.word_index) + 3'd1)) else $error("index step");
endmodule
